// ----- hw/rtl/dsls_pkg.sv -----
// Shared types, constants and helper functions for the dense softmax layer core.
// Used by every module of the block except dsls_ram, and by its port checker.
package dsls_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int MAX_INPUTS   = 64;
  localparam int MAX_OUTPUTS  = 16;
  localparam int ROW_W        = $clog2(MAX_OUTPUTS);
  localparam int COL_W        = $clog2(MAX_INPUTS);
  localparam int WADDR_W      = ROW_W + COL_W;
  localparam int WEIGHT_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int ACC_W        = 40;
  localparam int LOGIT_W      = 32;
  localparam int PROD_W       = 2 * DATA_WIDTH;
  localparam int PL_W         = PROD_W + 17;
  localparam int EXP_W        = 18;
  localparam int SUM_W        = 21;
  localparam int NUM_W        = 30;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic signed [13:0] LOG2E_Q12 = 14'sd5909;

  localparam logic [2:0] MODE_LOAD_W = 3'd0;
  localparam logic [2:0] MODE_LOAD_B = 3'd1;
  localparam logic [2:0] MODE_FWD    = 3'd2;
  localparam logic [2:0] MODE_DER    = 3'd3;
  localparam logic [2:0] MODE_READ_W = 3'd4;
  localparam logic [2:0] MODE_READ_B = 3'd5;

  localparam logic [1:0] KIND_PROB   = 2'd0;
  localparam logic [1:0] KIND_DELTA  = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;
  localparam logic [1:0] KIND_BIAS   = 2'd3;

  localparam logic [1:0] CFG_LR   = 2'd0;
  localparam logic [1:0] CFG_NIN  = 2'd1;
  localparam logic [1:0] CFG_NOUT = 2'd2;

  typedef enum logic [2:0] {
    OP_LDW = 3'd0,
    OP_LDB = 3'd1,
    OP_FWD = 3'd2,
    OP_DER = 3'd3,
    OP_RDW = 3'd4,
    OP_RDB = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        row;
    logic [5:0]        column;
    logic signed [15:0] value;
    logic              final_element;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [5:0]        position;
    logic signed [15:0] result_value;
    logic              last_of_run;
  } res_t;

  typedef struct packed {
    op_t               op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic signed [DATA_WIDTH-1:0] value;
    logic              fin;
  } cmd_t;

  function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] i);
    logic [EXP_W-1:0] r;
    case (i)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88753;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [PL_W-1:0] x);
    logic signed [PL_W-1:0] hi;
    logic signed [PL_W-1:0] lo;
    hi = PL_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    lo = -hi - PL_W'(1);
    if (x > hi) return hi[DATA_WIDTH-1:0];
    if (x < lo) return lo[DATA_WIDTH-1:0];
    return x[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [LOGIT_W-1:0] sat_logit(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -hi - ACC_W'(1);
    if (x > hi) return hi[LOGIT_W-1:0];
    if (x < lo) return lo[LOGIT_W-1:0];
    return x[LOGIT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/dsls_ram.sv -----
// Generic single-write, single-read RAM with registered, enabled read.
// Standalone; no package dependency.
module dsls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/dsls_front.sv -----
// Front end: takes requests and queues known modes; unknown ones are dropped.
// Depends on dsls_pkg.
module dsls_front (
  input  logic          request_valid,
  input  dsls_pkg::req_t request,
  output logic          request_stall,
  input  logic          q_full,
  output logic          push,
  output dsls_pkg::cmd_t push_cmd
);
  import dsls_pkg::*;

  logic known;
  op_t  op;

  always_comb begin
    known = 1'b1;
    op    = OP_LDW;
    case (request.mode)
      MODE_LOAD_W: op = OP_LDW;
      MODE_LOAD_B: op = OP_LDB;
      MODE_FWD:    op = OP_FWD;
      MODE_DER:    op = OP_DER;
      MODE_READ_W: op = OP_RDW;
      MODE_READ_B: op = OP_RDB;
      default:     known = 1'b0;
    endcase
  end

  assign request_stall = q_full;
  assign push          = request_valid && !q_full && known;

  always_comb begin
    push_cmd.op    = op;
    push_cmd.row   = request.row;
    push_cmd.col   = request.column;
    push_cmd.value = request.value;
    push_cmd.fin   = request.final_element;
  end

endmodule

// ----- hw/rtl/dsls_queue.sv -----
// Short command queue between the front end and the execution back end.
// Depends on dsls_pkg.
module dsls_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dsls_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output dsls_pkg::cmd_t cmd
);
  import dsls_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       count;

  assign full  = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/dsls_back.sv -----
// Back end: stores, shared MAC pipeline, softmax sequencer, divider, result register.
// Depends on dsls_pkg and dsls_ram.
module dsls_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  dsls_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output logic          result_valid,
  input  logic          result_stall,
  output dsls_pkg::res_t result
);
  import dsls_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_READ    = 13'b0000000000010,
    ST_MAC     = 13'b0000000000100,
    ST_DRAIN   = 13'b0000000001000,
    ST_EXP_RD  = 13'b0000000010000,
    ST_EXP_SUB = 13'b0000000100000,
    ST_EXP_MUL = 13'b0000001000000,
    ST_EXP_INT = 13'b0000010000000,
    ST_EXP_SHF = 13'b0000100000000,
    ST_DIV_RD  = 13'b0001000000000,
    ST_DIV_LD  = 13'b0010000000000,
    ST_DIV_IT  = 13'b0100000000000,
    ST_DIV_OUT = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_FWD = 2'd0,
    PH_BWD = 2'd1,
    PH_UPD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [COL_W-1:0] outer;
    logic [COL_W-1:0] inner;
    logic             first;
    logic             last;
    logic             is_bias;
  } tag_t;

  state_t state;
  phase_t phase;

  logic [15:0]      lr;
  logic [6:0]       n_in;
  logic [4:0]       n_out;
  logic [6:0]       cfg_nin_next;
  logic [4:0]       cfg_nout_next;

  logic [6:0]       oc;
  logic [6:0]       ic;
  logic [6:0]       lim_o;
  logic [6:0]       lim_i;
  logic             last_i;
  logic             last_o;
  tag_t             tag0;

  logic             v1, v2, v3;
  tag_t             tag1, tag2, tag3;
  logic signed [PROD_W-1:0] prod2;
  logic signed [ACC_W-1:0]  init2;
  logic signed [DATA_WIDTH-1:0] old2, old3;
  logic             sneg2, szero2, sneg3, szero3;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PL_W-1:0]   pl3;
  logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic             adv;
  logic             slot_free;
  logic             fin_fwd;
  logic             fin_bwd;
  logic             upd_wr;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [LOGIT_W-1:0] logit_c;
  logic signed [ACC_W-1:0]  acc_sgn;
  logic signed [ACC_W-1:0]  delta_rnd;
  logic signed [DATA_WIDTH-1:0] delta_c;
  logic signed [PL_W-1:0]   step;
  logic signed [DATA_WIDTH-1:0] upd_c;

  logic signed [LOGIT_W-1:0] m;
  logic [SUM_W-1:0] ssum;
  logic signed [LOGIT_W:0]   dreg;
  logic signed [46:0]        tprod;
  logic signed [34:0]        treg;
  logic signed [22:0]        kval;
  logic [EXP_W-1:0] t0, t1, vval, vreg;
  logic [12:0]      tdiff;
  logic [20:0]      interp;
  logic             big;
  logic [4:0]       shreg;
  logic [EXP_W-1:0] eval_c;

  logic [NUM_W-1:0] quo;
  logic [SUM_W-1:0] rem;
  logic [SUM_W:0]   r2;
  logic [4:0]       dcnt;

  logic [1:0]       rd_kind;
  logic [5:0]       rd_pos;

  logic             emit;
  res_t             emit_res;

  logic                  w_we, w_re;
  logic [WADDR_W-1:0]    w_waddr, w_raddr;
  logic [DATA_WIDTH-1:0] w_wdata, w_rdata;
  logic                  b_we, b_re;
  logic [ROW_W-1:0]      b_waddr, b_raddr;
  logic [DATA_WIDTH-1:0] b_wdata, b_rdata;
  logic                  x_we, x_re;
  logic [COL_W-1:0]      x_waddr, x_raddr;
  logic [DATA_WIDTH-1:0] x_wdata, x_rdata;
  logic                  d_we, d_re;
  logic [ROW_W-1:0]      d_waddr, d_raddr;
  logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
  logic                  g_we, g_re;
  logic [ROW_W-1:0]      g_waddr, g_raddr;
  logic [LOGIT_W-1:0]    g_wdata, g_rdata;

  dsls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WEIGHT_DEPTH)) u_weight (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );
  dsls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_OUTPUTS)) u_bias (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );
  dsls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_INPUTS)) u_input (
    .clk, .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .re(x_re), .raddr(x_raddr), .rdata(x_rdata)
  );
  dsls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_OUTPUTS)) u_deriv (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );
  dsls_ram #(.WIDTH(LOGIT_W), .DEPTH(MAX_OUTPUTS)) u_logit (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );

  always_comb begin
    cfg_nin_next = cfg_data[6:0];
    if (cfg_nin_next == '0) begin
      cfg_nin_next = 7'd1;
    end else if (cfg_nin_next > 7'(MAX_INPUTS)) begin
      cfg_nin_next = 7'(MAX_INPUTS);
    end
    cfg_nout_next = cfg_data[4:0];
    if (cfg_nout_next == '0) begin
      cfg_nout_next = 5'd1;
    end else if (cfg_nout_next > 5'(MAX_OUTPUTS)) begin
      cfg_nout_next = 5'(MAX_OUTPUTS);
    end
  end

  // issue control
  always_comb begin
    case (phase)
      PH_FWD: begin
        lim_o = {2'b0, n_out};
        lim_i = n_in;
      end
      PH_BWD: begin
        lim_o = n_in;
        lim_i = {2'b0, n_out};
      end
      default: begin
        lim_o = {2'b0, n_out};
        lim_i = n_in + 7'd1;
      end
    endcase
    last_i        = ic == lim_i - 7'd1;
    last_o        = oc == lim_o - 7'd1;
    tag0.outer    = oc[COL_W-1:0];
    tag0.inner    = ic[COL_W-1:0];
    tag0.first    = ic == '0;
    tag0.last     = last_i;
    tag0.is_bias  = (phase == PH_UPD) && (ic == n_in);
  end

  assign slot_free = !result_valid || !result_stall;
  assign fin_fwd   = v3 && tag3.last && (phase == PH_FWD);
  assign fin_bwd   = v3 && tag3.last && (phase == PH_BWD);
  assign upd_wr    = v3 && (phase == PH_UPD);
  assign adv       = !(fin_bwd && !slot_free);

  // stage 2 multiplier operands
  always_comb begin
    case (phase)
      PH_FWD: begin
        mul_a = $signed(w_rdata);
        mul_b = $signed(x_rdata);
      end
      PH_BWD: begin
        mul_a = $signed(w_rdata);
        mul_b = $signed(d_rdata);
      end
      default: begin
        mul_a = $signed(d_rdata);
        mul_b = tag1.is_bias ? DATA_WIDTH'(16'sd4096) : $signed(x_rdata);
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // stage 4 finishing arithmetic
  always_comb begin
    acc_rnd   = (acc + ACC_W'(2048)) >>> 12;
    logit_c   = sat_logit(acc_rnd);
    if (sneg3) begin
      acc_sgn = -acc;
    end else if (szero3) begin
      acc_sgn = '0;
    end else begin
      acc_sgn = acc;
    end
    delta_rnd = (acc_sgn + ACC_W'(2048)) >>> 12;
    delta_c   = sat_data(PL_W'(delta_rnd));
    step      = (pl3 + (PL_W'(1) <<< 27)) >>> 28;
    upd_c     = sat_data(PL_W'(old3) - step);
  end

  // exp datapath
  always_comb begin
    tprod  = 47'(dreg) * 47'(LOG2E_Q12);
    kval   = 23'(treg >>> 12);
    t0     = pow2_tab({1'b0, treg[11:8]});
    t1     = pow2_tab(5'({1'b0, treg[11:8]}) + 5'd1);
    tdiff  = 13'(t1 - t0);
    interp = 21'(tdiff) * 21'(treg[7:0]);
    vval   = t0 + EXP_W'(interp[20:8]);
    eval_c = big ? '0 : (vreg >> shreg);
    r2     = {rem, quo[NUM_W-1]};
  end

  // RAM port control
  always_comb begin
    w_we = 1'b0; w_re = 1'b0; w_waddr = '0; w_raddr = '0; w_wdata = '0;
    b_we = 1'b0; b_re = 1'b0; b_waddr = '0; b_raddr = '0; b_wdata = '0;
    x_we = 1'b0; x_re = 1'b0; x_waddr = '0; x_raddr = '0; x_wdata = '0;
    d_we = 1'b0; d_re = 1'b0; d_waddr = '0; d_raddr = '0; d_wdata = '0;
    g_we = 1'b0; g_re = 1'b0; g_waddr = '0; g_raddr = '0; g_wdata = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_LDW: begin
              w_we    = 1'b1;
              w_waddr = {cmd.row, cmd.col};
              w_wdata = cmd.value;
            end
            OP_LDB: begin
              b_we    = 1'b1;
              b_waddr = cmd.row;
              b_wdata = cmd.value;
            end
            OP_FWD: begin
              x_we    = 1'b1;
              x_waddr = cmd.col;
              x_wdata = cmd.value;
            end
            OP_DER: begin
              d_we    = 1'b1;
              d_waddr = cmd.row;
              d_wdata = cmd.value;
            end
            OP_RDW: begin
              w_re    = 1'b1;
              w_raddr = {cmd.row, cmd.col};
            end
            OP_RDB: begin
              b_re    = 1'b1;
              b_raddr = cmd.row;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        if (adv) begin
          w_re = 1'b1; b_re = 1'b1; x_re = 1'b1; d_re = 1'b1;
          case (phase)
            PH_FWD: begin
              w_raddr = {oc[ROW_W-1:0], ic[COL_W-1:0]};
              x_raddr = ic[COL_W-1:0];
              b_raddr = oc[ROW_W-1:0];
            end
            PH_BWD: begin
              w_raddr = {ic[ROW_W-1:0], oc[COL_W-1:0]};
              d_raddr = ic[ROW_W-1:0];
              x_raddr = oc[COL_W-1:0];
            end
            default: begin
              w_raddr = {oc[ROW_W-1:0], ic[COL_W-1:0]};
              d_raddr = oc[ROW_W-1:0];
              x_raddr = ic[COL_W-1:0];
              b_raddr = oc[ROW_W-1:0];
            end
          endcase
        end
      end
      ST_EXP_RD, ST_DIV_RD: begin
        g_re    = 1'b1;
        g_raddr = oc[ROW_W-1:0];
      end
      ST_EXP_SHF: begin
        g_we    = 1'b1;
        g_waddr = oc[ROW_W-1:0];
        g_wdata = LOGIT_W'(eval_c);
      end
      default: ;
    endcase
    if (fin_fwd && adv) begin
      g_we    = 1'b1;
      g_waddr = tag3.outer[ROW_W-1:0];
      g_wdata = logit_c;
    end
    if (upd_wr) begin
      if (tag3.is_bias) begin
        b_we    = 1'b1;
        b_waddr = tag3.outer[ROW_W-1:0];
        b_wdata = upd_c;
      end else begin
        w_we    = 1'b1;
        w_waddr = {tag3.outer[ROW_W-1:0], tag3.inner};
        w_wdata = upd_c;
      end
    end
  end

  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  // result selection
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    if (state == ST_READ && slot_free) begin
      emit                  = 1'b1;
      emit_res.kind         = rd_kind;
      emit_res.position     = rd_pos;
      emit_res.result_value = (rd_kind == KIND_BIAS) ? $signed(b_rdata) : $signed(w_rdata);
      emit_res.last_of_run  = 1'b1;
    end else if (fin_bwd && adv) begin
      emit                  = 1'b1;
      emit_res.kind         = KIND_DELTA;
      emit_res.position     = tag3.outer;
      emit_res.result_value = delta_c;
      emit_res.last_of_run  = {1'b0, tag3.outer} == n_in - 7'd1;
    end else if (state == ST_DIV_OUT && slot_free) begin
      emit                  = 1'b1;
      emit_res.kind         = KIND_PROB;
      emit_res.position     = oc[5:0];
      emit_res.result_value = $signed(quo[DATA_WIDTH-1:0]);
      emit_res.last_of_run  = oc[4:0] == n_out - 5'd1;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      tag1 <= tag0;
      tag2 <= tag1;
      tag3 <= tag2;
      if (v1) begin
        prod2  <= mul_p;
        init2  <= (phase == PH_FWD) ? (ACC_W'($signed(b_rdata)) <<< 12) : '0;
        old2   <= tag1.is_bias ? $signed(b_rdata) : $signed(w_rdata);
        sneg2  <= x_rdata[DATA_WIDTH-1];
        szero2 <= x_rdata == '0;
      end
      if (v2) begin
        acc    <= (tag2.first ? init2 : acc) + ACC_W'(prod2);
        pl3    <= PL_W'($signed({1'b0, lr})) * PL_W'(prod2);
        old3   <= old2;
        sneg3  <= sneg2;
        szero3 <= szero2;
      end
    end
    if (fin_fwd && adv && (tag3.outer == '0 || logit_c > m)) begin
      m <= logit_c;
    end
    if (emit) begin
      result <= emit_res;
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_FWD;
      lr           <= LR_RESET;
      n_in         <= 7'(MAX_INPUTS);
      n_out        <= 5'(MAX_OUTPUTS);
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      oc           <= '0;
      ic           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LR:   lr    <= cfg_data;
          CFG_NIN:  n_in  <= cfg_nin_next;
          CFG_NOUT: n_out <= cfg_nout_next;
          default: ;
        endcase
      end

      if (adv) begin
        v1 <= (state == ST_MAC);
        v2 <= v1;
        v3 <= v2;
      end

      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_FWD: begin
                if (cmd.fin) begin
                  state <= ST_MAC;
                  phase <= PH_FWD;
                  oc    <= '0;
                  ic    <= '0;
                end
              end
              OP_DER: begin
                if (cmd.fin) begin
                  state <= ST_MAC;
                  phase <= PH_BWD;
                  oc    <= '0;
                  ic    <= '0;
                end
              end
              OP_RDW: begin
                state   <= ST_READ;
                rd_kind <= KIND_WEIGHT;
                rd_pos  <= cmd.col;
              end
              OP_RDB: begin
                state   <= ST_READ;
                rd_kind <= KIND_BIAS;
                rd_pos  <= 6'(cmd.row);
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        ST_MAC: begin
          if (adv) begin
            if (last_i) begin
              ic <= '0;
              if (last_o) begin
                state <= ST_DRAIN;
              end else begin
                oc <= oc + 7'd1;
              end
            end else begin
              ic <= ic + 7'd1;
            end
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            case (phase)
              PH_FWD: begin
                state <= ST_EXP_RD;
                oc    <= '0;
                ssum  <= '0;
              end
              PH_BWD: begin
                state <= ST_MAC;
                phase <= PH_UPD;
                oc    <= '0;
                ic    <= '0;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_EXP_RD: state <= ST_EXP_SUB;
        ST_EXP_SUB: begin
          dreg  <= (LOGIT_W + 1)'($signed(g_rdata)) - (LOGIT_W + 1)'(m);
          state <= ST_EXP_MUL;
        end
        ST_EXP_MUL: begin
          treg  <= 35'(tprod >>> 12);
          state <= ST_EXP_INT;
        end
        ST_EXP_INT: begin
          vreg  <= vval;
          big   <= kval < -23'sd31;
          shreg <= 5'(-kval);
          state <= ST_EXP_SHF;
        end
        ST_EXP_SHF: begin
          ssum <= ssum + SUM_W'(eval_c);
          if (oc[4:0] == n_out - 5'd1) begin
            oc    <= '0;
            state <= ST_DIV_RD;
          end else begin
            oc    <= oc + 7'd1;
            state <= ST_EXP_RD;
          end
        end
        ST_DIV_RD: state <= ST_DIV_LD;
        ST_DIV_LD: begin
          quo   <= {g_rdata[EXP_W-1:0], 12'b0} + NUM_W'(ssum >> 1);
          rem   <= '0;
          dcnt  <= '0;
          state <= ST_DIV_IT;
        end
        ST_DIV_IT: begin
          if (r2 >= {1'b0, ssum}) begin
            rem <= SUM_W'(r2 - {1'b0, ssum});
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= r2[SUM_W-1:0];
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          if (dcnt == 5'(NUM_W - 1)) begin
            state <= ST_DIV_OUT;
          end else begin
            dcnt <= dcnt + 5'd1;
          end
        end
        ST_DIV_OUT: begin
          if (slot_free) begin
            if (oc[4:0] == n_out - 5'd1) begin
              state <= ST_IDLE;
            end else begin
              oc    <= oc + 7'd1;
              state <= ST_DIV_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dense_softmax_layer_sgd_core.sv -----
// A forward vector is processed once its final element arrives, as is a derivative
// vector: one MAC per cycle on the weight RAM port, paused while a delta result is
// stalled, then for a forward vector an exp and a divide per neuron. Synchronous rst
// clears control and restores configuration defaults; the stores hold no reset value.
module dense_softmax_layer_sgd_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_stall,
  input  dsls_pkg::req_t request,
  output logic           result_valid,
  input  logic           result_stall,
  output dsls_pkg::res_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import dsls_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  dsls_front u_front (
    .request_valid, .request, .request_stall,
    .q_full, .push, .push_cmd
  );

  dsls_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full(q_full),
    .pop(q_pop), .valid(q_valid), .cmd(q_cmd)
  );

  dsls_back u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop),
    .cfg_valid, .cfg_index, .cfg_data,
    .result_valid, .result_stall, .result
  );

endmodule

// ----- hw/rtl/dsls_checker.sv -----
// Port-level checks on the result channel of the core.
// Depends on dsls_pkg; bound to dense_softmax_layer_sgd_core below.
module dsls_port_checks (
  input logic           clk,
  input logic           rst,
  input logic           result_valid,
  input logic           result_stall,
  input dsls_pkg::res_t result
);
  import dsls_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_PROB |->
      result.result_value >= 16'sd0 && result.result_value <= 16'sd4096)
    else $error("probability out of range");

  a_prob_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_PROB |-> result.position < 6'(MAX_OUTPUTS))
    else $error("probability position out of range");

  a_readback_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_WEIGHT || result.kind == KIND_BIAS) |->
      result.last_of_run)
    else $error("readback not marked last");

endmodule

bind dense_softmax_layer_sgd_core dsls_port_checks u_dsls_port_checks (.*);
